[sv/erm_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// erm_pkg: shared types and constants for the element restriction MAC
// Coarse node count, fixed point layout, opcodes and the cell control word.
// ----------------------------------------------------------------------------
package erm_pkg;

	localparam int COARSE_NODES     = 8;
	localparam int IDX_W            = $clog2(COARSE_NODES);
	localparam int PEND_W           = $clog2(COARSE_NODES + 1);
	localparam int FRAC_BITS        = 16;
	localparam int ACC_GUARD        = 8;
	localparam int CFG_W            = 7;
	localparam int CHILD_IDX_W      = 7;
	localparam int ROW_W            = 3;
	localparam int MAX_CHILDREN_DEF = 125;
	localparam int SAMPLE_WIDTH_DEF = 32;
	localparam int WEIGHT_WIDTH_DEF = 18;
	localparam logic [CFG_W-1:0] CHILDREN_RESET = 7'd125;

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_PUSH  = 1'b1
	} op_t;

	typedef struct packed {
		logic rd_en;   // fetch coefficient column for an accepted push
		logic mul_en;  // product stage load
		logic acc_en;  // accumulate product
		logic dump;    // element closes: move sum to chain, clear accumulator
		logic shift;   // chain moves one place toward the output
	} cell_ctl_t;

endpackage
`default_nettype wire

[sv/erm_cell.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// erm_cell: one coarse node row of the restriction MAC
// Holds its coefficient row, multiplies the broadcast sample, accumulates,
// and passes finished sums along the result chain.
// ----------------------------------------------------------------------------
module erm_cell #(
	parameter int MAX_CHILDREN = erm_pkg::MAX_CHILDREN_DEF,
	parameter int SAMPLE_WIDTH = erm_pkg::SAMPLE_WIDTH_DEF,
	parameter int WEIGHT_WIDTH = erm_pkg::WEIGHT_WIDTH_DEF,
	localparam int AW    = $clog2(MAX_CHILDREN),
	localparam int PW    = SAMPLE_WIDTH + WEIGHT_WIDTH,
	localparam int ACC_W = PW + erm_pkg::ACC_GUARD
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  erm_pkg::cell_ctl_t            ctl,
	input  wire                           wr_en,
	input  wire        [AW-1:0]           wr_addr,
	input  wire        [WEIGHT_WIDTH-1:0] wr_data,
	input  wire        [AW-1:0]           rd_addr,
	input  wire signed [SAMPLE_WIDTH-1:0] sample_s1,
	input  wire signed [ACC_W-1:0]        chain_in,
	output logic signed [ACC_W-1:0]       chain_out
);

	logic        [WEIGHT_WIDTH-1:0] weight_mem_q [MAX_CHILDREN];
	logic signed [WEIGHT_WIDTH-1:0] weight_s1;
	logic signed [PW-1:0]           prod_s2;
	logic signed [ACC_W-1:0]        acc_q;
	logic signed [ACC_W-1:0]        hold_q;
	logic signed [ACC_W-1:0]        sum;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			weight_mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			weight_s1 <= weight_mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			prod_s2 <= sample_s1 * weight_s1;
		end
	end

	assign sum = acc_q + ACC_W'(prod_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctl.acc_en) begin
			acc_q <= ctl.dump ? '0 : sum;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.dump) begin
			hold_q <= sum;
		end else if (ctl.shift) begin
			hold_q <= chain_in;
		end
	end

	assign chain_out = hold_q;

endmodule
`default_nettype wire

[sv/erm_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// erm_ctrl: sequencing for the restriction MAC
// Child counter, element close detection, MAC pipeline valids, result chain
// occupancy and input backpressure.
// ----------------------------------------------------------------------------
module erm_ctrl #(
	parameter int MAX_CHILDREN = erm_pkg::MAX_CHILDREN_DEF,
	localparam int AW = $clog2(MAX_CHILDREN)
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                cfg_wr_en,
	input  wire  [erm_pkg::CFG_W-1:0]          cfg_wr_data,
	input  wire                                in_valid,
	input  wire                                opcode,
	input  wire  [erm_pkg::CHILD_IDX_W-1:0]    child_index,
	input  wire                                out_valid,
	input  wire                                out_stall,
	output logic                               in_stall,
	output logic                               wr_accept,
	output logic [AW-1:0]                      wr_addr,
	output logic [AW-1:0]                      rd_addr,
	output erm_pkg::cell_ctl_t                 ctl,
	output logic [erm_pkg::PEND_W-1:0]         pending
);

	localparam int CNT_W = ($clog2(MAX_CHILDREN + 1) > erm_pkg::CFG_W) ?
		$clog2(MAX_CHILDREN + 1) : erm_pkg::CFG_W;

	logic [erm_pkg::CFG_W-1:0]  cfg_q;
	logic [AW-1:0]              counter_q;
	logic [erm_pkg::PEND_W-1:0] pending_q;
	logic                       push_s1, end_s1, push_s2, end_s2;
	logic [CNT_W-1:0]           cnt_ext, count_eff;
	logic                       is_end, busy, accept, push, load;

	always_comb begin
		cnt_ext = CNT_W'(cfg_q);
		if (cnt_ext == '0) begin
			count_eff = CNT_W'(1);
		end else if (cnt_ext > CNT_W'(MAX_CHILDREN)) begin
			count_eff = CNT_W'(MAX_CHILDREN);
		end else begin
			count_eff = cnt_ext;
		end
	end

	assign is_end = (CNT_W'(counter_q) + CNT_W'(1)) >= count_eff;

	// a closing push waits until the chain is empty and no close is in flight
	assign busy     = end_s1 || end_s2 || (pending_q != '0);
	assign in_stall = (opcode == erm_pkg::OP_PUSH) && is_end && busy;
	assign accept   = in_valid && !in_stall;
	assign push     = accept && (opcode == erm_pkg::OP_PUSH);

	assign wr_accept = accept && (opcode == erm_pkg::OP_WRITE) &&
		(32'(child_index) < 32'(MAX_CHILDREN));
	assign wr_addr   = AW'(child_index);
	assign rd_addr   = counter_q;

	assign load = (pending_q != '0) && (!out_valid || !out_stall);

	always_comb begin
		ctl.rd_en  = push;
		ctl.mul_en = push_s1;
		ctl.acc_en = push_s2;
		ctl.dump   = end_s2;
		ctl.shift  = load;
	end

	assign pending = pending_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q     <= erm_pkg::CHILDREN_RESET;
			counter_q <= '0;
			pending_q <= '0;
			push_s1   <= 1'b0;
			end_s1    <= 1'b0;
			push_s2   <= 1'b0;
			end_s2    <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				cfg_q <= cfg_wr_data;
			end
			if (push) begin
				counter_q <= is_end ? '0 : counter_q + AW'(1);
			end
			push_s1 <= push;
			end_s1  <= push && is_end;
			push_s2 <= push_s1;
			end_s2  <= end_s1;
			if (end_s2) begin
				pending_q <= erm_pkg::PEND_W'(erm_pkg::COARSE_NODES);
			end else if (load) begin
				pending_q <= pending_q - erm_pkg::PEND_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

[sv/erm_outstage.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// erm_outstage: rounding, saturation and output register
// Takes the sum at the head of the chain, rounds half up to Q16.16,
// clips to the sample range and holds the word until it is taken.
// ----------------------------------------------------------------------------
module erm_outstage #(
	parameter int SAMPLE_WIDTH = erm_pkg::SAMPLE_WIDTH_DEF,
	parameter int WEIGHT_WIDTH = erm_pkg::WEIGHT_WIDTH_DEF,
	localparam int ACC_W = SAMPLE_WIDTH + WEIGHT_WIDTH + erm_pkg::ACC_GUARD
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               load,
	input  wire  [erm_pkg::PEND_W-1:0]        pending,
	input  wire  signed [ACC_W-1:0]           head,
	input  wire                               out_stall,
	output logic                              out_valid,
	output logic [erm_pkg::IDX_W-1:0]         coarse_index,
	output logic signed [SAMPLE_WIDTH-1:0]    coarse_value,
	output logic                              saturated,
	output logic                              last
);

	localparam int QW = ACC_W + 1 - erm_pkg::FRAC_BITS;
	localparam int HW = QW - SAMPLE_WIDTH + 1;

	logic signed [ACC_W:0]          rnd;
	logic        [QW-1:0]           q;
	logic        [HW-1:0]           q_hi;
	logic                           clip;
	logic        [SAMPLE_WIDTH-1:0] val;
	logic        [SAMPLE_WIDTH-1:0] smax;

	assign rnd  = (ACC_W + 1)'(head) + (ACC_W + 1)'(1 << (erm_pkg::FRAC_BITS - 1));
	assign q    = rnd[ACC_W:erm_pkg::FRAC_BITS];
	assign q_hi = q[QW-1:SAMPLE_WIDTH-1];
	// in range only when the sign bit and everything above it agree
	assign clip = !((q_hi == '0) || (q_hi == '1));
	assign smax = {1'b0, {(SAMPLE_WIDTH - 1){1'b1}}};
	assign val  = clip ? (q[QW-1] ? ~smax : smax) : q[SAMPLE_WIDTH-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			coarse_index <= erm_pkg::IDX_W'(erm_pkg::PEND_W'(erm_pkg::COARSE_NODES) - pending);
			coarse_value <= val;
			saturated    <= clip;
			last         <= (pending == erm_pkg::PEND_W'(1));
		end
	end

endmodule
`default_nettype wire

[sv/element_restriction_mac.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// element_restriction_mac: per-element multigrid restriction MAC
// Eight row cells hold the coefficient table and accumulate fine values.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall): opcode 0 writes one coefficient at
// (child_index, coarse_row); opcode 1 pushes one fine value in child order.
// Writes with child_index beyond the table are dropped.
// Output channel (out_valid/out_stall): after children_per_element pushes,
// eight words for coarse nodes 0..7 follow, last set on node 7.
// Config: cfg_wr_en/cfg_wr_data set children_per_element (0 acts as 1,
// values above the table depth act as the depth); write only while idle.
// Throughput: one item per cycle. A push that closes an element is held off
// while the previous element's words are still in the result chain or a
// close is still in the MAC pipeline; with 11 or more children per element
// draining fully overlaps the next element.
// A close passes end_s1, end_s2 and pending_q before the first word is
// registered, then one word per cycle while out_stall is low. A stalled
// receiver freezes the output word and chain; only closing pushes back up.
// Reset clears counters, accumulators and config (125); the coefficient
// table is not cleared and must be written before use.
// ----------------------------------------------------------------------------
module element_restriction_mac #(
	parameter int MAX_CHILDREN = erm_pkg::MAX_CHILDREN_DEF,
	parameter int SAMPLE_WIDTH = erm_pkg::SAMPLE_WIDTH_DEF,
	parameter int WEIGHT_WIDTH = erm_pkg::WEIGHT_WIDTH_DEF
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                cfg_wr_en,
	input  wire  [erm_pkg::CFG_W-1:0]          cfg_wr_data,
	input  wire                                in_valid,
	output logic                               in_stall,
	input  wire                                opcode,
	input  wire  [erm_pkg::CHILD_IDX_W-1:0]    child_index,
	input  wire  [erm_pkg::ROW_W-1:0]          coarse_row,
	input  wire  signed [WEIGHT_WIDTH-1:0]     coefficient,
	input  wire  signed [SAMPLE_WIDTH-1:0]     fine_value,
	output logic                               out_valid,
	input  wire                                out_stall,
	output logic [erm_pkg::IDX_W-1:0]          coarse_index,
	output logic signed [SAMPLE_WIDTH-1:0]     coarse_value,
	output logic                               saturated,
	output logic                               last
);

	localparam int AW    = $clog2(MAX_CHILDREN);
	localparam int ACC_W = SAMPLE_WIDTH + WEIGHT_WIDTH + erm_pkg::ACC_GUARD;
	localparam int NODES = erm_pkg::COARSE_NODES;

	erm_pkg::cell_ctl_t         ctl;
	logic                       wr_accept;
	logic [AW-1:0]              wr_addr, rd_addr;
	logic [erm_pkg::PEND_W-1:0] pending;
	logic signed [SAMPLE_WIDTH-1:0] sample_s1;
	logic signed [ACC_W-1:0]    hold [NODES];

	erm_ctrl #(
		.MAX_CHILDREN(MAX_CHILDREN)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.opcode     (opcode),
		.child_index(child_index),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.in_stall   (in_stall),
		.wr_accept  (wr_accept),
		.wr_addr    (wr_addr),
		.rd_addr    (rd_addr),
		.ctl        (ctl),
		.pending    (pending)
	);

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			sample_s1 <= fine_value;
		end
	end

	for (genvar j = 0; j < NODES; j++) begin : g_cell
		logic signed [ACC_W-1:0] chain_in;

		if (j == NODES - 1) begin : g_tail
			assign chain_in = '0;
		end else begin : g_link
			assign chain_in = hold[j+1];
		end

		erm_cell #(
			.MAX_CHILDREN(MAX_CHILDREN),
			.SAMPLE_WIDTH(SAMPLE_WIDTH),
			.WEIGHT_WIDTH(WEIGHT_WIDTH)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.wr_en    (wr_accept && (coarse_row == erm_pkg::ROW_W'(j))),
			.wr_addr  (wr_addr),
			.wr_data  (coefficient),
			.rd_addr  (rd_addr),
			.sample_s1(sample_s1),
			.chain_in (chain_in),
			.chain_out(hold[j])
		);
	end

	erm_outstage #(
		.SAMPLE_WIDTH(SAMPLE_WIDTH),
		.WEIGHT_WIDTH(WEIGHT_WIDTH)
	) u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (ctl.shift),
		.pending     (pending),
		.head        (hold[0]),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.coarse_index(coarse_index),
		.coarse_value(coarse_value),
		.saturated   (saturated),
		.last        (last)
	);

endmodule
`default_nettype wire

[sv/erm_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// erm_checker: port-level checks for the restriction MAC
// Output word ordering, last marking, saturation values and hold on stall.
// ----------------------------------------------------------------------------
module erm_checker #(
	parameter int SAMPLE_WIDTH = erm_pkg::SAMPLE_WIDTH_DEF
) (
	input wire                              clk,
	input wire                              arst_n,
	input wire                              out_valid,
	input wire                              out_stall,
	input wire [erm_pkg::IDX_W-1:0]         coarse_index,
	input wire [SAMPLE_WIDTH-1:0]           coarse_value,
	input wire                              saturated,
	input wire                              last
);

	localparam logic [SAMPLE_WIDTH-1:0] SMAX = {1'b0, {(SAMPLE_WIDTH - 1){1'b1}}};
	localparam logic [SAMPLE_WIDTH-1:0] SMIN = {1'b1, {(SAMPLE_WIDTH - 1){1'b0}}};

	// node 7 and only node 7 closes an element
	a_last_idx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last == (coarse_index == erm_pkg::IDX_W'(erm_pkg::COARSE_NODES - 1))))
		else $error("last flag does not match coarse node 7");

	// words of one element follow back to back in node order
	a_seq: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last |=>
		out_valid && (coarse_index == $past(coarse_index) + erm_pkg::IDX_W'(1)))
		else $error("coarse word missing or out of order");

	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |-> (coarse_value == SMAX) || (coarse_value == SMIN))
		else $error("saturated word not at a range limit");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(coarse_index) &&
		$stable(coarse_value) && $stable(saturated) && $stable(last))
		else $error("stalled output word changed");

endmodule

bind element_restriction_mac erm_checker #(
	.SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_erm_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.coarse_index(coarse_index),
	.coarse_value(coarse_value),
	.saturated   (saturated),
	.last        (last)
);
`default_nettype wire
